// ----- hw/rtl/multicart_outer_bank_mapper_top_assert.svh -----
// ----------------------------------------------------------------------------
// multicart outer bank mapper assertion macros
// shared concurrent assertion forms clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef MULTICART_OUTER_BANK_MAPPER_TOP_ASSERT_SVH
`define MULTICART_OUTER_BANK_MAPPER_TOP_ASSERT_SVH

// checked only while out of reset
`define MCOBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MCOBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mcobm_pkg.sv -----
// ----------------------------------------------------------------------------
// mcobm_pkg
// shared types and codes of the multicart outer bank mapper
// ----------------------------------------------------------------------------
package mcobm_pkg;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_PRG   = 2'd1;
    localparam logic [1:0] REQ_CHR   = 2'd2;

    // outer mode bit positions
    localparam int MODE_NROM256  = 2;
    localparam int MODE_PRG16    = 3;
    localparam int MODE_CHR_B7   = 4;
    localparam int MODE_NROM     = 5;
    localparam int MODE_CHR128   = 6;
    localparam int MODE_LOCK     = 7;

    localparam int BANK_W = 9;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] bus_addr;
        logic [7:0]  value;
        logic        wram_writable;
        logic [7:0]  inner_prg_six;
        logic [7:0]  inner_prg_seven;
    } t_req_word;

    typedef struct packed {
        logic [BANK_W-1:0] bank_number;
        logic              write_taken;
    } t_rsp_word;

    typedef struct packed {
        logic [7:0] mode;
        logic       chr_hi;
    } t_outer_state;

endpackage

// ----- hw/rtl/mcobm_latch.sv -----
// ----------------------------------------------------------------------------
// mcobm_latch
// outer mode latch and high chr bit, with wram and lock gating
// ----------------------------------------------------------------------------
module mcobm_latch (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_req,
    input  logic                  i_wram_writable,
    input  logic [7:0]            i_data,
    input  logic                  i_addr_b8,
    output logic                  o_taken,
    output mcobm_pkg::t_outer_state o_state
);
    import mcobm_pkg::*;

    t_outer_state r_state;
    t_outer_state n_state;

    assign o_taken = i_wr_req && i_wram_writable && !r_state.mode[MODE_LOCK];

    always_comb begin
        n_state = r_state;
        if (o_taken) begin
            n_state.mode   = i_data;
            n_state.chr_hi = i_addr_b8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ----- hw/rtl/mcobm_xlate.sv -----
// ----------------------------------------------------------------------------
// mcobm_xlate
// prg and chr bank translation from the outer mode latch
// ----------------------------------------------------------------------------
module mcobm_xlate (
    input  logic [1:0]                     i_req_type,
    input  logic [1:0]                     i_slot,
    input  logic [7:0]                     i_inner,
    input  logic [7:0]                     i_reg_six,
    input  logic [7:0]                     i_reg_seven,
    input  mcobm_pkg::t_outer_state        i_state,
    output logic [mcobm_pkg::BANK_W-1:0]   o_bank
);
    import mcobm_pkg::*;

    logic [4:0] prg_mask;
    logic [5:0] prg_outer;
    logic [7:0] nrom_src;
    logic [4:0] nrom_part;
    logic [5:0] prg_bank;
    logic [7:0] chr_mask;
    logic [8:0] chr_outer;
    logic [8:0] chr_bank;

    always_comb begin
        prg_mask  = i_state.mode[MODE_PRG16] ? 5'h0F : 5'h1F;
        prg_outer = {i_state.mode[1:0], 4'b0000} & ~{1'b0, prg_mask};
        nrom_src  = i_slot[0] ? i_reg_seven : i_reg_six;
        nrom_part = nrom_src[4:0] & prg_mask;
        if (i_state.mode[MODE_NROM]) begin
            if (i_state.mode[MODE_NROM256]) begin
                prg_bank = prg_outer | {1'b0, nrom_part[4:2], i_slot};
            end else begin
                prg_bank = prg_outer | {1'b0, nrom_part[4:1], i_slot[0]};
            end
        end else begin
            prg_bank = prg_outer | {1'b0, i_inner[4:0] & prg_mask};
        end

        chr_mask  = i_state.mode[MODE_CHR128] ? 8'h7F : 8'hFF;
        chr_outer = {i_state.chr_hi, i_state.mode[MODE_CHR_B7], 7'b0};
        chr_bank  = (chr_outer & ~{1'b0, chr_mask}) | {1'b0, i_inner & chr_mask};

        case (i_req_type)
            REQ_PRG: o_bank = {3'b000, prg_bank};
            REQ_CHR: o_bank = chr_bank;
            default: o_bank = '0;
        endcase
    end

endmodule

// ----- hw/rtl/multicart_outer_bank_mapper_top.sv -----
// flow: a word accepted into the input register moves on to the result register
// throughput: one word per cycle; a stalled result holds both registers, and
//   in ready drops once the input register is full as well
// reset: i_rst_n synchronous active low clears both valid flags, the mode
//   latch and the high chr bit
// ----------------------------------------------------------------------------
// multicart_outer_bank_mapper_top
// outer banking layer over an mmc3: mode latch writes and prg/chr translation
// ----------------------------------------------------------------------------
`include "multicart_outer_bank_mapper_top_assert.svh"

module multicart_outer_bank_mapper_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mcobm_pkg::t_req_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output mcobm_pkg::t_rsp_word  o_out_word
);
    import mcobm_pkg::*;

    // input register stage
    logic      r_in_vld;
    t_req_word r_in;

    // result register stage
    logic      r_out_vld;
    t_rsp_word r_out;
    t_rsp_word n_out;

    logic          advance;
    logic          taken;
    logic [BANK_W-1:0] bank;
    t_outer_state  outer_state;

    // the result register frees when empty or being taken this cycle
    assign advance    = !r_out_vld || i_out_ready;
    // input register frees when empty or moving into the result register
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    // latch updates exactly when the write word moves to the result stage,
    // so later words in the input register see the new mode next cycle
    mcobm_latch u_latch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_req        (r_in_vld && advance && (r_in.req_type == REQ_WRITE)),
        .i_wram_writable (r_in.wram_writable),
        .i_data          (r_in.value),
        .i_addr_b8       (r_in.bus_addr[8]),
        .o_taken         (taken),
        .o_state         (outer_state)
    );

    // prg slot is cpu address bits 14:13
    mcobm_xlate u_xlate (
        .i_req_type  (r_in.req_type),
        .i_slot      (r_in.bus_addr[14:13]),
        .i_inner     (r_in.value),
        .i_reg_six   (r_in.inner_prg_six),
        .i_reg_seven (r_in.inner_prg_seven),
        .i_state     (outer_state),
        .o_bank      (bank)
    );

    always_comb begin
        n_out.bank_number = bank;
        n_out.write_taken = taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // a write result never carries a bank number
    `MCOBM_ASSERT(a_write_no_bank, r_out_vld |-> !(r_out.write_taken && (r_out.bank_number != '0)), "write result carries bank")
    // a locked mode latch never changes
    `MCOBM_ASSERT(a_lock_holds, outer_state.mode[MODE_LOCK] |=> $stable(outer_state), "locked latch changed")
    // an empty input register always takes a word
    `MCOBM_ASSERT(a_empty_ready, !r_in_vld |-> o_in_ready, "empty input stage not ready")
    // reset empties both stages
    `MCOBM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_in_vld && !r_out_vld), "stages valid after reset")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the multicart outer bank mapper: drives request
// words through the valid/ready input, predicts every response word from a
// local copy of the mode latch and compares it field by field on the output
// ----------------------------------------------------------------------------
module testbench;
    import mcobm_pkg::*;

    // type 3 has no package code, it is the unused request slot
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 1000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;    // settle time after the last result
    localparam int MAX_SHOWN    = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      in_valid    = 1'b0;
    t_req_word in_word     = '0;
    logic      out_ready   = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_rsp_word o_out_word;

    // predictor copy of the outer latches
    logic [7:0] mode_q   = 8'h00;
    logic       chr_hi_q = 1'b0;

    t_rsp_word  bank_rsp_q[$];

    // shared knobs between the test tasks and the two driving sides
    bit quiet    = 1'b0;   // no random idling on either side
    bit hold_req = 1'b0;   // ask the receiver for one long hold-off

    int unsigned mismatches     = 0;
    int unsigned checked        = 0;
    int unsigned writes_taken   = 0;
    int unsigned writes_refused = 0;
    int unsigned prg_queries    = 0;
    int unsigned chr_queries    = 0;
    int unsigned none_queries   = 0;
    int unsigned stall_cycles   = 0;

    multicart_outer_bank_mapper_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // 8 KiB prg bank for one cpu slot
    function automatic logic [8:0] prg_bank_of(logic [1:0] slot, logic [7:0] inner,
                                               logic [7:0] r6, logic [7:0] r7);
        logic [8:0] mask;
        logic [8:0] outer;
        logic [8:0] src;
        mask  = mode_q[MODE_PRG16] ? 9'h00F : 9'h01F;
        // outer base bits 1:0 land on bank bits 5:4, masked by the window
        outer = {3'b000, mode_q[1:0], 4'b0000} & 9'h030 & ~mask;
        if (mode_q[MODE_NROM]) begin
            // nrom modes take odd slots from reg 7, even slots from reg 6
            src = slot[0] ? {1'b0, r7} : {1'b0, r6};
            if (mode_q[MODE_NROM256])
                return outer | (src & mask & ~9'h003) | {7'b0, slot};
            return outer | (src & mask & ~9'h001) | {8'b0, slot[0]};
        end
        return outer | ({1'b0, inner} & mask);
    endfunction

    // 1 KiB chr bank
    function automatic logic [8:0] chr_bank_of(logic [7:0] inner);
        logic [8:0] mask;
        logic [8:0] outer;
        mask  = mode_q[MODE_CHR128] ? 9'h07F : 9'h0FF;
        outer = {chr_hi_q, mode_q[MODE_CHR_B7], 7'b0};
        return (outer & ~mask) | ({1'b0, inner} & mask);
    endfunction

    // expected response of one request word, updates the latch copy
    function automatic t_rsp_word mapper_predict(t_req_word w);
        t_rsp_word r;
        r = '0;
        case (w.req_type)
            REQ_WRITE: begin
                if (w.wram_writable && !mode_q[MODE_LOCK]) begin
                    mode_q        = w.value;
                    chr_hi_q      = w.bus_addr[8];
                    r.write_taken = 1'b1;
                    writes_taken++;
                end else begin
                    writes_refused++;
                end
            end
            REQ_PRG: begin
                r.bank_number = prg_bank_of(w.bus_addr[14:13], w.value,
                                            w.inner_prg_six, w.inner_prg_seven);
                prg_queries++;
            end
            REQ_CHR: begin
                r.bank_number = chr_bank_of(w.value);
                chr_queries++;
            end
            default: begin
                none_queries++;
            end
        endcase
        return r;
    endfunction

    // input monitor: every accepted request word gets its expectation
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_ready)
            bank_rsp_q.push_back(mapper_predict(in_word));
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic note_failure(string what, t_rsp_word exp_w, t_rsp_word got_w);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] %s: expected bank %0d taken %0d, got bank %0d taken %0d",
                     $realtime, what, exp_w.bank_number, exp_w.write_taken,
                     got_w.bank_number, got_w.write_taken);
    endtask

    // output checker: oldest expectation against each accepted response word
    always @(posedge i_clk) begin
        t_rsp_word exp_w;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (bank_rsp_q.size() == 0) begin
                note_failure("response word with nothing expected", '0, o_out_word);
            end else begin
                exp_w = bank_rsp_q.pop_front();
                checked++;
                if (o_out_word.bank_number !== exp_w.bank_number)
                    note_failure("bank_number mismatch", exp_w, o_out_word);
                else if (o_out_word.write_taken !== exp_w.write_taken)
                    note_failure("write_taken mismatch", exp_w, o_out_word);
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver side: random ready, with a quiet mode and one long hold-off
    // ------------------------------------------------------------------
    always begin
        @(posedge i_clk);
        if (hold_req) begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_req = 1'b0;
        end else if (quiet) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 33);
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one request word; entered and left at a rising edge, and on
    // return the word has just been accepted with valid still high
    task automatic send_word(t_req_word w);
        int unsigned gap;
        if (!quiet && $urandom_range(99) < 33) begin
            gap = $urandom_range(4, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        // ready only moves at rising edges, so look at it mid-cycle
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // drop valid and hold until every expected response word is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        wait (bank_rsp_q.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic t_req_word mk_word(logic [1:0] req, logic [15:0] addr,
                                          logic [7:0] val, logic wram,
                                          logic [7:0] r6, logic [7:0] r7);
        t_req_word w;
        w.req_type        = req;
        w.bus_addr        = addr;
        w.value           = val;
        w.wram_writable   = wram;
        w.inner_prg_six   = r6;
        w.inner_prg_seven = r7;
        return w;
    endfunction

    // random request word; mode_write gives a well-formed latch write
    function automatic t_req_word rand_word(bit mode_write, bit allow_lock);
        t_req_word w;
        w = mk_word(REQ_PRG, 16'($urandom_range(16'hFFFF, 0)), 8'($urandom_range(255, 0)),
                    1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                    8'($urandom_range(255, 0)));
        if (mode_write) begin
            w.req_type      = REQ_WRITE;
            w.wram_writable = ($urandom_range(99) < 90);
            if (!allow_lock)
                w.value[MODE_LOCK] = 1'b0;
        end else begin
            case ($urandom_range(9))
                0:       w.req_type = REQ_NONE;
                1: begin
                    // noise: a write that wram protection refuses
                    w.req_type      = REQ_WRITE;
                    w.wram_writable = 1'b0;
                end
                2, 3, 4, 5: w.req_type = REQ_PRG;
                default: w.req_type = REQ_CHR;
            endcase
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset state, refused write, every window and nrom mode, field extremes
    task automatic test_directed_modes();
        send_word(mk_word(REQ_PRG,   16'h0000, 8'hFF, 1'b0, 8'h00, 8'h00));
        send_word(mk_word(REQ_CHR,   16'hFFFF, 8'hFF, 1'b1, 8'hFF, 8'hFF));
        // write refused while wram is protected
        send_word(mk_word(REQ_WRITE, 16'hFFFF, 8'h3F, 1'b0, 8'hFF, 8'hFF));
        send_word(mk_word(REQ_PRG,   16'hE000, 8'h00, 1'b1, 8'hFF, 8'hFF));
        // nrom-256, 16-bank window, outer base 3, chr bits 7 and 8 set
        send_word(mk_word(REQ_WRITE, 16'h0100, 8'h3F, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_PRG,   16'h8000, 8'h55, 1'b1, 8'hFF, 8'h00));
        send_word(mk_word(REQ_PRG,   16'hA000, 8'h55, 1'b1, 8'hFF, 8'h00));
        send_word(mk_word(REQ_PRG,   16'hC000, 8'h55, 1'b1, 8'hFF, 8'h00));
        send_word(mk_word(REQ_PRG,   16'hE000, 8'h55, 1'b1, 8'hFF, 8'h00));
        send_word(mk_word(REQ_CHR,   16'h0000, 8'h00, 1'b0, 8'h00, 8'h00));
        send_word(mk_word(REQ_CHR,   16'h0000, 8'hFF, 1'b0, 8'h00, 8'h00));
        // mmc3 banking through the 16-bank window
        send_word(mk_word(REQ_WRITE, 16'h0000, 8'h1B, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_PRG,   16'hA000, 8'hFF, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_PRG,   16'h6000, 8'h00, 1'b1, 8'h00, 8'h00));
        // nrom-128 plus 128-bank chr window, bit 8 of the address clear
        send_word(mk_word(REQ_WRITE, 16'hFEFF, 8'h60, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_PRG,   16'h8000, 8'h12, 1'b0, 8'hAA, 8'h55));
        send_word(mk_word(REQ_PRG,   16'hA000, 8'h12, 1'b0, 8'hAA, 8'h55));
        send_word(mk_word(REQ_CHR,   16'hFFFF, 8'hFF, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_CHR,   16'hFFFF, 8'h00, 1'b1, 8'h00, 8'h00));
        // unused request type gives an all-zero response
        send_word(mk_word(REQ_NONE,  16'hFFFF, 8'hFF, 1'b1, 8'hFF, 8'hFF));
        // 32-bank window with outer base 3
        send_word(mk_word(REQ_WRITE, 16'h0000, 8'h03, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_PRG,   16'hC000, 8'hFF, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_WRITE, 16'h0000, 8'h00, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_PRG,   16'hC000, 8'hFF, 1'b1, 8'h00, 8'h00));
    endtask

    // mode writes each followed by a short run of translations
    task automatic test_random_traffic(int unsigned n_words, bit allow_lock);
        int unsigned sent;
        int unsigned run_len;
        sent = 0;
        while (sent < n_words) begin
            // middle third runs with no idling at all
            quiet = (sent >= n_words / 3) && (sent < 2 * n_words / 3);
            if ($urandom_range(99) < 30) begin
                send_word(rand_word(1'b1, allow_lock));
                sent++;
            end
            run_len = $urandom_range(6, 2);
            repeat (run_len) begin
                send_word(rand_word(1'b0, allow_lock));
                sent++;
            end
        end
        quiet = 1'b0;
    endtask

    // receiver holds off long enough to fill the block, then the sender
    // pauses until everything is back
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (30) send_word(rand_word($urandom_range(3) == 0, 1'b0));
        wait_drained();
        repeat (10) send_word(rand_word($urandom_range(3) == 0, 1'b0));
    endtask

    // set the lock bit; every later write must be refused
    task automatic test_lock_latch();
        send_word(mk_word(REQ_WRITE, 16'h01FF, 8'hFF, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_PRG,   16'hE000, 8'h00, 1'b1, 8'h3C, 8'hC3));
        send_word(mk_word(REQ_WRITE, 16'h0000, 8'h00, 1'b1, 8'h00, 8'h00));
        send_word(mk_word(REQ_CHR,   16'h0000, 8'h00, 1'b1, 8'h00, 8'h00));
        test_random_traffic(40, 1'b1);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_modes();
        test_backpressure();
        test_random_traffic(300, 1'b0);
        test_lock_latch();

        // all stimulus accepted: drain, then let the pipeline settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d taken and %0d refused writes, %0d prg, %0d chr, %0d unused",
                 writes_taken, writes_refused, prg_queries, chr_queries, none_queries);
        $display("%0d response words checked, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && bank_rsp_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
